// ===== hw/rtl/nkrk_pkg.sv =====
// Package for the nearest-k reading keeper.
// Holds the stored entry type, field widths and default constants.
// No dependencies.
package nkrk_pkg;

  localparam int RangeW   = 20;
  localparam int AddrW    = 8;
  localparam int AngleW   = 16;
  localparam int MaxKeptW = 5;

  localparam int                  MaxEntriesDef = 16;
  localparam logic [MaxKeptW-1:0] MaxKeptReset  = 5'd10;

  // One kept reading as it sits in the store.
  typedef struct packed {
    logic        [RangeW-1:0] rng;
    logic        [AddrW-1:0]  addr;
    logic signed [AngleW-1:0] h_bearing;
    logic signed [AngleW-1:0] v_bearing;
    logic signed [AngleW-1:0] rel_heading;
  } entry_t;

endpackage

// ===== hw/rtl/nkrk_mem.sv =====
// Entry store of the nearest-k reading keeper.
// One write port, one read port, registered read data.
// Depends on nkrk_pkg.
module nkrk_mem #(
  parameter int  Depth = nkrk_pkg::MaxEntriesDef,
  localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IdxW-1:0]     waddr_i,
  input  nkrk_pkg::entry_t    wdata_i,
  input  logic                re_i,
  input  logic [IdxW-1:0]     raddr_i,
  output nkrk_pkg::entry_t    rdata_o
);

  nkrk_pkg::entry_t mem_q [Depth];
  nkrk_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/nkrk_ctrl.sv =====
// Sequencer of the nearest-k reading keeper: append, farthest scan, shift,
// emission and the output register. Drives the entry store.
// Depends on nkrk_pkg.
module nkrk_ctrl #(
  parameter int  MaxEntries = nkrk_pkg::MaxEntriesDef,
  localparam int IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1,
  localparam int CntW = $clog2(MaxEntries + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [nkrk_pkg::MaxKeptW-1:0] max_kept_i,
  // input item
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          has_reading_i,
  input  nkrk_pkg::entry_t              in_entry_i,
  input  logic                          frame_end_i,
  // result item
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          entry_valid_o,
  output nkrk_pkg::entry_t              out_entry_o,
  output logic                          last_o,
  // store port
  output logic                          mem_we_o,
  output logic [IdxW-1:0]               mem_waddr_o,
  output nkrk_pkg::entry_t              mem_wdata_o,
  output logic                          mem_re_o,
  output logic [IdxW-1:0]               mem_raddr_o,
  input  nkrk_pkg::entry_t              mem_rdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAKE,
    ST_SCAN,
    ST_SHIFT,
    ST_PLACE,
    ST_EMIT_START,
    ST_EMIT_EMPTY,
    ST_EMIT_LD
  } state_e;

  state_e                      state_q, state_d;
  nkrk_pkg::entry_t            item_q;
  logic                        has_q, fend_q;
  logic [CntW-1:0]             count_q, count_d;
  logic [IdxW-1:0]             idx_q, idx_d;
  logic [IdxW-1:0]             far_idx_q, far_idx_d;
  logic [nkrk_pkg::RangeW-1:0] far_rng_q, far_rng_d;
  nkrk_pkg::entry_t            out_q, out_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_ev_q, out_ev_d;
  logic                        out_last_q, out_last_d;

  logic [CntW-1:0]             limit;
  logic [CntW-1:0]             cnt_last;
  logic                        idx_is_last;
  logic [IdxW-1:0]             idx_nx;
  logic                        out_free;
  logic [IdxW-1:0]             far_idx_upd;
  logic [nkrk_pkg::RangeW-1:0] far_rng_upd;
  state_e                      done_state;
  logic                        in_acc;

  // Clamp the limit to one..MaxEntries.
  always_comb begin
    if (max_kept_i == '0) begin
      limit = CntW'(1);
    end else if (int'(max_kept_i) > MaxEntries) begin
      limit = CntW'(MaxEntries);
    end else begin
      limit = CntW'(max_kept_i);
    end
  end

  assign cnt_last    = count_q - CntW'(1);
  assign idx_is_last = (CntW'(idx_q) == cnt_last);
  assign idx_nx      = idx_q + IdxW'(1);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign done_state  = fend_q ? ST_EMIT_START : ST_IDLE;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;

  // Running farthest entry; strictly greater keeps the earliest on ties.
  always_comb begin
    if (idx_q == '0 || mem_rdata_i.rng > far_rng_q) begin
      far_idx_upd = idx_q;
      far_rng_upd = mem_rdata_i.rng;
    end else begin
      far_idx_upd = far_idx_q;
      far_rng_upd = far_rng_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    far_idx_d   = far_idx_q;
    far_rng_d   = far_rng_q;
    out_d       = out_q;
    out_ev_d    = out_ev_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we_o    = 1'b0;
    mem_waddr_o = IdxW'(count_q);
    mem_wdata_o = item_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (has_reading_i) begin
            state_d = ST_TAKE;
          end else if (frame_end_i) begin
            state_d = ST_EMIT_START;
          end
        end
      end
      ST_TAKE: begin
        if (count_q < limit) begin
          mem_we_o = 1'b1;
          count_d  = count_q + CntW'(1);
          state_d  = done_state;
        end else begin
          mem_re_o = 1'b1;
          idx_d    = '0;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        far_idx_d = far_idx_upd;
        far_rng_d = far_rng_upd;
        if (!idx_is_last) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_nx;
          idx_d       = idx_nx;
        end else if (far_rng_upd > item_q.rng) begin
          if (CntW'(far_idx_upd) == cnt_last) begin
            // Farthest is the tail: overwrite it in place.
            mem_we_o    = 1'b1;
            mem_waddr_o = IdxW'(cnt_last);
            state_d     = done_state;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = far_idx_upd + IdxW'(1);
            idx_d       = far_idx_upd;
            state_d     = ST_SHIFT;
          end
        end else begin
          state_d = done_state;
        end
      end
      ST_SHIFT: begin
        // Move entry idx+1 down to idx; the read runs two ahead of the write.
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q;
        mem_wdata_o = mem_rdata_i;
        if (CntW'(idx_q) + CntW'(1) == cnt_last) begin
          state_d = ST_PLACE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_nx + IdxW'(1);
          idx_d       = idx_nx;
        end
      end
      ST_PLACE: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = IdxW'(cnt_last);
        state_d     = done_state;
      end
      ST_EMIT_START: begin
        if (count_q == '0) begin
          state_d = ST_EMIT_EMPTY;
        end else begin
          mem_re_o = 1'b1;
          idx_d    = '0;
          state_d  = ST_EMIT_LD;
        end
      end
      ST_EMIT_EMPTY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          out_ev_d    = 1'b0;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_EMIT_LD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = mem_rdata_i;
          out_ev_d    = 1'b1;
          out_last_d  = idx_is_last;
          if (idx_is_last) begin
            count_d = '0;
            state_d = ST_IDLE;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = idx_nx;
            idx_d       = idx_nx;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_entry_i;
      has_q  <= has_reading_i;
      fend_q <= frame_end_i;
    end
    idx_q      <= idx_d;
    far_idx_q  <= far_idx_d;
    far_rng_q  <= far_rng_d;
    out_q      <= out_d;
    out_ev_q   <= out_ev_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign entry_valid_o = out_ev_q;
  assign out_entry_o   = out_q;
  assign last_o        = out_last_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= MaxEntries)
    else $error("kept count beyond store depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q > $past(count_q)) |-> (count_q == $past(count_q) + CntW'(1)))
    else $error("kept count grew by more than one");

  a_no_write_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (state_q != ST_EMIT_LD && state_q != ST_EMIT_START &&
                  state_q != ST_EMIT_EMPTY))
    else $error("store written during emission");

  a_take_needs_reading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TAKE) |-> has_q)
    else $error("take step without a reading");

  a_raddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re_o |-> (CntW'(mem_raddr_o) < count_q))
    else $error("read beyond kept entries");
`endif

endmodule

// ===== hw/rtl/nearest_k_reading_keeper.sv =====
// Nearest-k reading keeper: keeps the closest readings of a frame, up to max_kept.
// An append below the limit writes the tail; a full list reads every entry to find the farthest
// and, if it is strictly farther, shifts later entries down one per cycle, then places the new one.
// Emission: the results follow the frame end, one per cycle without stall.
// Reset (async, active low) clears the count and the output valid, sets max_kept to 10.
// Depends on nkrk_pkg, nkrk_mem, nkrk_ctrl.
module nearest_k_reading_keeper #(
  parameter int MaxEntries = nkrk_pkg::MaxEntriesDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [nkrk_pkg::MaxKeptW-1:0]        cfg_wdata_i,
  // input item
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 has_reading_i,
  input  logic [nkrk_pkg::RangeW-1:0]          range_i,
  input  logic [nkrk_pkg::AddrW-1:0]           address_i,
  input  logic signed [nkrk_pkg::AngleW-1:0]   horizontal_bearing_i,
  input  logic signed [nkrk_pkg::AngleW-1:0]   vertical_bearing_i,
  input  logic signed [nkrk_pkg::AngleW-1:0]   relative_heading_i,
  input  logic                                 frame_end_i,
  // result item
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 entry_valid_o,
  output logic [nkrk_pkg::RangeW-1:0]          out_range_o,
  output logic [nkrk_pkg::AddrW-1:0]           out_address_o,
  output logic signed [nkrk_pkg::AngleW-1:0]   out_horizontal_bearing_o,
  output logic signed [nkrk_pkg::AngleW-1:0]   out_vertical_bearing_o,
  output logic signed [nkrk_pkg::AngleW-1:0]   out_relative_heading_o,
  output logic                                 last_o
);

  localparam int IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;

  logic [nkrk_pkg::MaxKeptW-1:0] max_kept_q;
  nkrk_pkg::entry_t              in_entry;
  nkrk_pkg::entry_t              out_entry;
  logic                          mem_we, mem_re;
  logic [IdxW-1:0]               mem_waddr, mem_raddr;
  nkrk_pkg::entry_t              mem_wdata, mem_rdata;

  // Limit register; the user must write it only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_kept_q <= nkrk_pkg::MaxKeptReset;
    end else if (cfg_we_i) begin
      max_kept_q <= cfg_wdata_i;
    end
  end

  // Pack the reading fields into one store entry.
  always_comb begin
    in_entry.rng         = range_i;
    in_entry.addr        = address_i;
    in_entry.h_bearing   = horizontal_bearing_i;
    in_entry.v_bearing   = vertical_bearing_i;
    in_entry.rel_heading = relative_heading_i;
  end

  nkrk_ctrl #(
    .MaxEntries (MaxEntries)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .max_kept_i    (max_kept_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .has_reading_i (has_reading_i),
    .in_entry_i    (in_entry),
    .frame_end_i   (frame_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .entry_valid_o (entry_valid_o),
    .out_entry_o   (out_entry),
    .last_o        (last_o),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  // Ranges and payloads share one store; the sequencer never reads and
  // writes the same entry in one cycle.
  nkrk_mem #(
    .Depth (MaxEntries)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_range_o              = out_entry.rng;
  assign out_address_o            = out_entry.addr;
  assign out_horizontal_bearing_o = out_entry.h_bearing;
  assign out_vertical_bearing_o   = out_entry.v_bearing;
  assign out_relative_heading_o   = out_entry.rel_heading;

endmodule

// ===== tb/sv/tb_nearest_k_reading_keeper.sv =====
// Self-checking testbench for nearest_k_reading_keeper: directed table, then random frames.
// Predicts the kept list per frame and checks every result item against it.
// Depends on nkrk_pkg and the nearest_k_reading_keeper RTL.
module tb_nearest_k_reading_keeper;

  localparam int Depth      = nkrk_pkg::MaxEntriesDef;
  localparam int StallLimit = 2000;  // cycles with no handshake before giving up
  localparam int Settle     = 48;    // covers a full scan and shift over the store
  localparam int ReportMax  = 10;

  // One input item as the sender sees it.
  typedef struct packed {
    logic             has_rd;
    nkrk_pkg::entry_t rd;
    logic             fe;
  } reading_item_t;

  // One result item as the receiver sees it.
  typedef struct packed {
    logic             entry_valid;
    nkrk_pkg::entry_t rd;
    logic             last;
  } kept_result_t;

  typedef enum logic {ROW_ITEM, ROW_LIMIT} row_kind_e;

  typedef struct {
    row_kind_e                     kind;
    logic [nkrk_pkg::MaxKeptW-1:0] limit;
    reading_item_t                 it;
    bit                            has_want;
    kept_result_t                  want;
  } plan_row_t;

  localparam kept_result_t EmptyFrame =
    {1'b0, {$bits(nkrk_pkg::entry_t){1'b0}}, 1'b1};
  localparam nkrk_pkg::entry_t MaxEntry =
    {20'hFFFFF, 8'hFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
  localparam nkrk_pkg::entry_t MinEntry =
    {20'h00000, 8'h00, 16'h8000, 16'h8000, 16'h8000};

  // DUT ports; every input starts at a known value.
  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                cfg_we_i = 1'b0;
  logic [nkrk_pkg::MaxKeptW-1:0]       cfg_wdata_i = '0;
  logic                                in_valid_i = 1'b0;
  logic                                in_stall_o;
  logic                                has_reading_i = 1'b0;
  logic [nkrk_pkg::RangeW-1:0]         range_i = '0;
  logic [nkrk_pkg::AddrW-1:0]          address_i = '0;
  logic signed [nkrk_pkg::AngleW-1:0]  horizontal_bearing_i = '0;
  logic signed [nkrk_pkg::AngleW-1:0]  vertical_bearing_i = '0;
  logic signed [nkrk_pkg::AngleW-1:0]  relative_heading_i = '0;
  logic                                frame_end_i = 1'b0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic                                entry_valid_o;
  logic [nkrk_pkg::RangeW-1:0]         out_range_o;
  logic [nkrk_pkg::AddrW-1:0]          out_address_o;
  logic signed [nkrk_pkg::AngleW-1:0]  out_horizontal_bearing_o;
  logic signed [nkrk_pkg::AngleW-1:0]  out_vertical_bearing_o;
  logic signed [nkrk_pkg::AngleW-1:0]  out_relative_heading_o;
  logic                                last_o;

  nearest_k_reading_keeper #(.MaxEntries(Depth)) uut (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cfg_we_i                 (cfg_we_i),
    .cfg_wdata_i              (cfg_wdata_i),
    .in_valid_i               (in_valid_i),
    .in_stall_o               (in_stall_o),
    .has_reading_i            (has_reading_i),
    .range_i                  (range_i),
    .address_i                (address_i),
    .horizontal_bearing_i     (horizontal_bearing_i),
    .vertical_bearing_i       (vertical_bearing_i),
    .relative_heading_i       (relative_heading_i),
    .frame_end_i              (frame_end_i),
    .out_valid_o              (out_valid_o),
    .out_stall_i              (out_stall_i),
    .entry_valid_o            (entry_valid_o),
    .out_range_o              (out_range_o),
    .out_address_o            (out_address_o),
    .out_horizontal_bearing_o (out_horizontal_bearing_o),
    .out_vertical_bearing_o   (out_vertical_bearing_o),
    .out_relative_heading_o   (out_relative_heading_o),
    .last_o                   (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predicted state of the block: the kept list of the open frame and the limit.
  nkrk_pkg::entry_t              kept_tab [Depth];
  int                            kept_n = 0;
  logic [nkrk_pkg::MaxKeptW-1:0] limit_reg = nkrk_pkg::MaxKeptReset;

  // Results still owed by the block, oldest first.
  kept_result_t due_entries [$];

  // Directed stimulus table.
  plan_row_t plan [$];

  int  bad_results = 0;
  int  phase_items = 0;
  bit  no_idle = 1'b0;     // set for a stretch without gaps or stalls
  int  hold_left = 0;
  int  quiet_cycles = 0;

  // Append one owed result.
  function automatic void owe_result(input kept_result_t r);
    due_entries = {due_entries, r};
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(input plan_row_t r);
    plan = {plan, r};
  endfunction

  // Fold one accepted item into the predicted list; queue the results of a frame end.
  // Return how many results were queued.
  function automatic int keep_nearest(input reading_item_t it);
    int           lim;
    int           far_at;
    int           pushed;
    kept_result_t r;
    pushed = 0;
    if (it.has_rd) begin
      lim = int'(limit_reg);
      if (lim == 0) lim = 1;
      if (lim > Depth) lim = Depth;
      if (kept_n < lim) begin
        kept_tab[kept_n] = it.rd;
        kept_n++;
      end else begin
        // Find the farthest entry; strict compare keeps the earliest on a tie.
        far_at = 0;
        for (int i = 1; i < kept_n; i++) begin
          if (kept_tab[i].rng > kept_tab[far_at].rng) far_at = i;
        end
        // Drop it only if strictly farther, shift the rest down, append the new one.
        if (kept_tab[far_at].rng > it.rd.rng) begin
          for (int i = far_at; i + 1 < kept_n; i++) kept_tab[i] = kept_tab[i + 1];
          kept_tab[kept_n - 1] = it.rd;
        end
      end
    end
    if (it.fe) begin
      if (kept_n == 0) begin
        owe_result(EmptyFrame);
        pushed = 1;
      end else begin
        for (int i = 0; i < kept_n; i++) begin
          r.entry_valid = 1'b1;
          r.rd          = kept_tab[i];
          r.last        = (i == kept_n - 1);
          owe_result(r);
          pushed++;
        end
      end
      kept_n = 0;
    end
    return pushed;
  endfunction

  // Idle length: mostly none, often short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic nkrk_pkg::entry_t random_entry();
    nkrk_pkg::entry_t e;
    case ($urandom_range(0, 3))
      0:       e.rng = nkrk_pkg::RangeW'($urandom_range(0, 7) * 100);   // ties likely
      1:       e.rng = 20'hFFFFF - nkrk_pkg::RangeW'($urandom_range(0, 3));
      default: e.rng = nkrk_pkg::RangeW'($urandom());
    endcase
    e.addr        = nkrk_pkg::AddrW'($urandom());
    e.h_bearing   = nkrk_pkg::AngleW'($urandom());
    e.v_bearing   = nkrk_pkg::AngleW'($urandom());
    e.rel_heading = nkrk_pkg::AngleW'($urandom());
    return e;
  endfunction

  // Directed readings: angles derived from the address so every field differs.
  function automatic nkrk_pkg::entry_t reading(input int unsigned rng, input logic [7:0] a);
    return {nkrk_pkg::RangeW'(rng), a, {a, ~a}, {~a, a}, {a, a}};
  endfunction

  function automatic plan_row_t item_row(input logic h, input nkrk_pkg::entry_t e,
                                         input logic fe);
    plan_row_t p;
    p.kind     = ROW_ITEM;
    p.limit    = '0;
    p.it       = {h, e, fe};
    p.has_want = 1'b0;
    p.want     = EmptyFrame;
    return p;
  endfunction

  function automatic plan_row_t fixed_row(input logic h, input nkrk_pkg::entry_t e,
                                          input logic fe, input kept_result_t w);
    plan_row_t p;
    p          = item_row(h, e, fe);
    p.has_want = 1'b1;
    p.want     = w;
    return p;
  endfunction

  function automatic plan_row_t limit_row(input logic [nkrk_pkg::MaxKeptW-1:0] v);
    plan_row_t p;
    p       = item_row(1'b0, '0, 1'b0);
    p.kind  = ROW_LIMIT;
    p.limit = v;
    return p;
  endfunction

  // Present one item and hold it until the block takes it.
  task automatic send_item(input reading_item_t it);
    in_valid_i           <= 1'b1;
    has_reading_i        <= it.has_rd;
    range_i              <= it.rd.rng;
    address_i            <= it.rd.addr;
    horizontal_bearing_i <= it.rd.h_bearing;
    vertical_bearing_i   <= it.rd.v_bearing;
    relative_heading_i   <= it.rd.rel_heading;
    frame_end_i          <= it.fe;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (it.has_rd || it.fe) phase_items++;
  endtask

  task automatic idle_gap();
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic offer(input reading_item_t it);
    send_item(it);
    void'(keep_nearest(it));
    idle_gap();
  endtask

  // Change the limit only once every owed result is out and the block has settled.
  task automatic write_limit(input logic [nkrk_pkg::MaxKeptW-1:0] v);
    in_valid_i <= 1'b0;
    while (due_entries.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    limit_reg    = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One random frame: readings with some noise mixed in, closed by a frame end,
  // either on the last reading or as a bare marker.
  task automatic run_frame();
    int            n;
    int            eff;
    reading_item_t it;
    it  = '0;
    eff = (limit_reg == 0) ? 1 : ((int'(limit_reg) > Depth) ? Depth : int'(limit_reg));
    n   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, eff + 3);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 11) == 0) begin
        offer({1'b0, random_entry(), 1'b0});
      end
      it.has_rd = 1'b1;
      it.rd     = random_entry();
      it.fe     = (k == n - 1) && ($urandom_range(0, 1) == 1);
      offer(it);
    end
    if (n == 0 || !it.fe) begin
      offer({1'b0, random_entry(), 1'b1});
    end
  endtask

  // Receiver: random stalls, held for a random number of cycles.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!no_idle && $urandom_range(0, 3) == 0) begin
      hold_left   <= gap_len();
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Check each accepted result against the oldest owed one.
  always @(posedge clk_i) begin : rx_check
    kept_result_t got;
    kept_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {entry_valid_o, out_range_o, out_address_o, out_horizontal_bearing_o,
             out_vertical_bearing_o, out_relative_heading_o, last_o};
      if (due_entries.size() == 0) begin
        if (bad_results < ReportMax)
          $display("unexpected result: got ev=%0d rng=%05h addr=%02h h=%04h v=%04h",
                   got.entry_valid, got.rd.rng, got.rd.addr, got.rd.h_bearing,
                   got.rd.v_bearing, " rh=%04h last=%0d", got.rd.rel_heading, got.last);
        bad_results++;
      end else begin
        want = due_entries.pop_front();
        if (got.entry_valid !== want.entry_valid || got.rd.rng !== want.rd.rng ||
            got.rd.addr !== want.rd.addr || got.rd.h_bearing !== want.rd.h_bearing ||
            got.rd.v_bearing !== want.rd.v_bearing ||
            got.rd.rel_heading !== want.rd.rel_heading || got.last !== want.last) begin
          if (bad_results < ReportMax) begin
            $display("result mismatch: want ev=%0d rng=%05h addr=%02h h=%04h v=%04h",
                     want.entry_valid, want.rd.rng, want.rd.addr, want.rd.h_bearing,
                     want.rd.v_bearing, " rh=%04h last=%0d",
                     want.rd.rel_heading, want.last);
            $display("                  got ev=%0d rng=%05h addr=%02h h=%04h v=%04h",
                     got.entry_valid, got.rd.rng, got.rd.addr, got.rd.h_bearing,
                     got.rd.v_bearing, " rh=%04h last=%0d",
                     got.rd.rel_heading, got.last);
          end
          bad_results++;
        end
      end
    end
  end

  // Watchdog: end the run if no handshake of any kind happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [nkrk_pkg::MaxKeptW-1:0] phase_lim [7];
    int                            added;

    // Directed table.
    // Frame end right after reset: one invalid result marked last, all reading fields zero.
    add_row(fixed_row(1'b0, reading(20'h12345, 8'hA5), 1'b1, EmptyFrame));
    // Neither reading nor frame end: ignore, whatever the fields hold.
    add_row(item_row(1'b0, {20'hFFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0));
    // Reading and frame end together, at both extremes of every field.
    add_row(fixed_row(1'b1, MaxEntry, 1'b1, {1'b1, MaxEntry, 1'b1}));
    add_row(fixed_row(1'b1, MinEntry, 1'b1, {1'b1, MinEntry, 1'b1}));
    // Bare frame end with junk fields: still an empty frame.
    add_row(fixed_row(1'b0, reading(20'hABCDE, 8'h5A), 1'b1, EmptyFrame));
    // Limit zero acts as one: replace only when strictly closer.
    add_row(limit_row(5'd0));
    add_row(item_row(1'b1, reading(500, 8'h01), 1'b0));
    add_row(item_row(1'b1, reading(300, 8'h02), 1'b0));
    add_row(item_row(1'b1, reading(300, 8'h03), 1'b0));
    add_row(item_row(1'b1, reading(700, 8'h04), 1'b1));
    // Ties on the farthest range: the earliest goes first.
    add_row(limit_row(5'd3));
    add_row(item_row(1'b1, reading(400, 8'h10), 1'b0));
    add_row(item_row(1'b1, reading(400, 8'h11), 1'b0));
    add_row(item_row(1'b1, reading(200, 8'h12), 1'b0));
    add_row(item_row(1'b1, reading(100, 8'h13), 1'b0));
    add_row(item_row(1'b1, reading(50, 8'h14), 1'b1));
    // Limit lowered mid-frame: the list is kept, new readings only replace.
    add_row(limit_row(5'd4));
    add_row(item_row(1'b1, reading(900, 8'h20), 1'b0));
    add_row(item_row(1'b1, reading(800, 8'h21), 1'b0));
    add_row(item_row(1'b1, reading(700, 8'h22), 1'b0));
    add_row(item_row(1'b1, reading(600, 8'h23), 1'b0));
    add_row(limit_row(5'd2));
    add_row(item_row(1'b1, reading(650, 8'h24), 1'b0));
    add_row(item_row(1'b1, reading(999, 8'h25), 1'b0));
    add_row(item_row(1'b0, reading(1, 8'h26), 1'b1));

    phase_lim = '{5'd16, 5'd31, 5'd1, 5'd5, 5'd0, 5'd7, 5'd0};
    phase_lim[6] = nkrk_pkg::MaxKeptW'($urandom_range(0, 31));

    // Hold reset, then release it on a falling edge, away from the rising edge.
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_LIMIT) begin
        write_limit(plan[i].limit);
      end else begin
        send_item(plan[i].it);
        added = keep_nearest(plan[i].it);
        // Typed-in rows: swap the predicted result for the one read off by hand.
        if (plan[i].has_want) begin
          repeat (added) void'(due_entries.pop_back());
          owe_result(plan[i].want);
        end
        idle_gap();
      end
    end

    // Random phases, one limit setting each; one phase runs without any idling.
    foreach (phase_lim[p]) begin
      write_limit(phase_lim[p]);
      no_idle     = (p == 3);
      phase_items = 0;
      while (phase_items < 12) run_frame();
      // Sometimes leave the frame open across the next limit change.
      if ($urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, 3)) offer({1'b1, random_entry(), 1'b0});
      end
    end
    no_idle = 1'b0;
    // Close any frame left open so the last list is checked too.
    offer({1'b0, random_entry(), 1'b1});

    // Drain: wait for every owed result, then let the block settle.
    in_valid_i <= 1'b0;
    while (due_entries.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);

    if (bad_results == 0 && due_entries.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
